// ===== hdl/bvm_pkg.sv =====
// shared types, constants and register codes of the battery voltage monitor
package bvm_pkg;

    localparam int SAMPLES_PER_ITEM = 4;
    localparam int ADC_BITS         = 12;
    localparam int ADC_SUM_W        = ADC_BITS + $clog2(SAMPLES_PER_ITEM);
    localparam int SCALE_W          = 20;
    localparam int PRODUCT_W        = ADC_SUM_W + SCALE_W;
    localparam int FRAC_BITS        = 16;
    localparam int MV_W             = 16;
    localparam int TIME_W           = 32;
    localparam int SUM_W            = 48;
    localparam int COUNT_W          = 32;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic [MV_W-1:0]      MV_MAX         = '1;
    localparam logic [MV_W-1:0]      MV_DISCONNECT  = MV_W'(1000);
    localparam logic [MV_W-1:0]      MV_FULL_MARGIN = MV_W'(200);
    localparam logic [SUM_W-1:0]     SUM_LIMIT      = '1;
    localparam logic [COUNT_W-1:0]   COUNT_LIMIT    = '1;

    localparam logic [SCALE_W-1:0]   MV_SCALE_RESET    = SCALE_W'(26409);
    localparam logic [MV_W-1:0]      CRITICAL_MV_RESET = MV_W'(3300);
    localparam logic [MV_W-1:0]      WARN_MV_RESET     = MV_W'(3500);
    localparam logic [MV_W-1:0]      FULL_MV_RESET     = MV_W'(4200);
    localparam logic [TIME_W-1:0]    INTERVAL_US_RESET = TIME_W'(100000);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MV_SCALE    = 3'd0,
        REG_CRITICAL_MV = 3'd1,
        REG_WARN_MV     = 3'd2,
        REG_FULL_MV     = 3'd3,
        REG_INTERVAL_US = 3'd4
    } cfg_reg_e;

    typedef enum logic [2:0] {
        HEALTH_DISCONNECTED = 3'd0,
        HEALTH_CRITICAL     = 3'd1,
        HEALTH_WARNING      = 3'd2,
        HEALTH_NOMINAL      = 3'd3,
        HEALTH_FULL         = 3'd4
    } health_e;

    typedef struct packed {
        logic [TIME_W-1:0]   time_us;
        logic                tracking;
        logic [ADC_BITS-1:0] sample_0;
        logic [ADC_BITS-1:0] sample_1;
        logic [ADC_BITS-1:0] sample_2;
        logic [ADC_BITS-1:0] sample_3;
    } in_item_t;

    typedef struct packed {
        logic [MV_W-1:0]    voltage_mv;
        logic [2:0]         health;
        logic               sampled;
        logic [MV_W-1:0]    min_mv;
        logic [MV_W-1:0]    max_mv;
        logic [SUM_W-1:0]   sum_mv;
        logic [COUNT_W-1:0] sample_count;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        logic              tracking;
        logic [MV_W-1:0]   voltage_mv;
    } meas_t;

    typedef struct packed {
        logic [MV_W-1:0]   critical_mv;
        logic [MV_W-1:0]   warn_mv;
        logic [MV_W-1:0]   full_mv;
        logic [TIME_W-1:0] interval_us;
    } thresh_t;

endpackage

// ===== hdl/bvm_in_if.sv =====
// request channel carrying timestamp, tracking flag and adc samples
interface bvm_in_if import bvm_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/bvm_out_if.sv =====
// result channel carrying voltage, health and statistics
interface bvm_out_if import bvm_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/battery_voltage_monitor_core.sv =====
// battery voltage monitor top level: config registers and the three-stage pipeline
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  meas     | in  | time_us, tracking, sample_0..sample_3
//  report   | out | voltage_mv, health, sampled, min_mv, max_mv, sum_mv, count
//  cfg_*    | in  | write enable, register index, write data
//
//  one request per cycle sustained while report is ready; each result is registered
//  in turn after adc sum, 14x20 scale multiply, then grading and statistics
//  reset clears the pipeline valids, the statistics and loads default config
//  a stall on report backs up stage by stage to meas.ready, nothing is dropped
module battery_voltage_monitor_core import bvm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    bvm_in_if.sink                 meas,
    bvm_out_if.source              report,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SCALE_W-1:0] mv_scale_reg;
    thresh_t            thresh_reg;

    logic               mid_valid;
    logic               mid_ready;
    meas_t              mid_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_scale_reg           <= MV_SCALE_RESET;
            thresh_reg.critical_mv <= CRITICAL_MV_RESET;
            thresh_reg.warn_mv     <= WARN_MV_RESET;
            thresh_reg.full_mv     <= FULL_MV_RESET;
            thresh_reg.interval_us <= INTERVAL_US_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MV_SCALE:    mv_scale_reg           <= cfg_data[SCALE_W-1:0];
                REG_CRITICAL_MV: thresh_reg.critical_mv <= cfg_data[MV_W-1:0];
                REG_WARN_MV:     thresh_reg.warn_mv     <= cfg_data[MV_W-1:0];
                REG_FULL_MV:     thresh_reg.full_mv     <= cfg_data[MV_W-1:0];
                REG_INTERVAL_US: thresh_reg.interval_us <= cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    bvm_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (meas.valid),
        .up_ready   (meas.ready),
        .up_item    (meas.item),
        .mv_scale   (mv_scale_reg),
        .down_valid (mid_valid),
        .down_ready (mid_ready),
        .down_item  (mid_item)
    );

    bvm_stats u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (mid_valid),
        .up_ready  (mid_ready),
        .up_item   (mid_item),
        .thresh    (thresh_reg),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .out_item  (report.item)
    );

endmodule

// ===== hdl/bvm_scale.sv =====
// two pipeline stages: adc sum, then scaling to saturated millivolts
module bvm_scale import bvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  in_item_t          up_item,
    input  logic [SCALE_W-1:0] mv_scale,
    output logic              down_valid,
    input  logic              down_ready,
    output meas_t             down_item
);

    logic                 s1_valid_reg;
    logic [ADC_SUM_W-1:0] s1_sum_reg;
    logic [TIME_W-1:0]    s1_time_reg;
    logic                 s1_tracking_reg;
    logic                 s2_valid_reg;
    meas_t                s2_item_reg;

    logic                 s1_ready;
    logic                 s2_ready;
    logic [ADC_SUM_W-1:0] sum_next;
    logic [PRODUCT_W-1:0] product;
    logic [MV_W-1:0]      mv_next;

    assign s2_ready = !s2_valid_reg || down_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    assign sum_next = ADC_SUM_W'(up_item.sample_0) + ADC_SUM_W'(up_item.sample_1)
                    + ADC_SUM_W'(up_item.sample_2) + ADC_SUM_W'(up_item.sample_3);

    assign product = PRODUCT_W'(s1_sum_reg) * PRODUCT_W'(mv_scale);

    always_comb
    begin
        if (|product[PRODUCT_W-1:FRAC_BITS+MV_W])
        begin
            mv_next = MV_MAX;
        end
        else
        begin
            mv_next = product[FRAC_BITS+MV_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && s1_ready)
        begin
            s1_sum_reg      <= sum_next;
            s1_time_reg     <= up_item.time_us;
            s1_tracking_reg <= up_item.tracking;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_item_reg.time_us    <= s1_time_reg;
            s2_item_reg.tracking   <= s1_tracking_reg;
            s2_item_reg.voltage_mv <= mv_next;
        end
    end

    assign down_valid = s2_valid_reg;
    assign down_item  = s2_item_reg;

endmodule

// ===== hdl/bvm_stats.sv =====
// health grading, interval statistics and the result register
module bvm_stats import bvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  meas_t     up_item,
    input  thresh_t   thresh,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic               tracking_before_reg;
    logic [MV_W-1:0]    lowest_reg;
    logic [MV_W-1:0]    highest_reg;
    logic [SUM_W-1:0]   total_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  last_take_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               advance;
    logic               rise;
    logic               take;
    logic [TIME_W-1:0]  elapsed;
    logic [MV_W-1:0]    nominal_top;
    health_e            health;
    logic [SUM_W:0]     total_sum;
    logic [MV_W-1:0]    lowest_next;
    logic [MV_W-1:0]    highest_next;
    logic [SUM_W-1:0]   total_next;
    logic [COUNT_W-1:0] count_next;
    logic [TIME_W-1:0]  last_take_next;

    assign up_ready = !out_valid_reg || out_ready;
    assign advance  = up_valid && up_ready;

    assign rise      = up_item.tracking && !tracking_before_reg;
    assign elapsed   = up_item.time_us - last_take_reg;
    assign take      = up_item.tracking && !rise && (elapsed >= thresh.interval_us);
    assign total_sum = {1'b0, total_reg} + (SUM_W+1)'(up_item.voltage_mv);

    assign nominal_top = (thresh.full_mv >= MV_FULL_MARGIN) ?
                         (thresh.full_mv - MV_FULL_MARGIN) : '0;

    always_comb
    begin
        priority if (up_item.voltage_mv < MV_DISCONNECT)
        begin
            health = HEALTH_DISCONNECTED;
        end
        else if (up_item.voltage_mv < thresh.critical_mv)
        begin
            health = HEALTH_CRITICAL;
        end
        else if (up_item.voltage_mv < thresh.warn_mv)
        begin
            health = HEALTH_WARNING;
        end
        else if (up_item.voltage_mv < nominal_top)
        begin
            health = HEALTH_NOMINAL;
        end
        else
        begin
            health = HEALTH_FULL;
        end
    end

    always_comb
    begin
        lowest_next    = lowest_reg;
        highest_next   = highest_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        last_take_next = last_take_reg;
        if (rise)
        begin
            lowest_next    = MV_MAX;
            highest_next   = '0;
            total_next     = '0;
            count_next     = '0;
            last_take_next = up_item.time_us;
        end
        else if (take)
        begin
            last_take_next = up_item.time_us;
            if (up_item.voltage_mv < lowest_reg)
            begin
                lowest_next = up_item.voltage_mv;
            end
            if (up_item.voltage_mv > highest_reg)
            begin
                highest_next = up_item.voltage_mv;
            end
            total_next = total_sum[SUM_W] ? SUM_LIMIT : total_sum[SUM_W-1:0];
            if (count_reg != COUNT_LIMIT)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_before_reg <= 1'b0;
            lowest_reg          <= MV_MAX;
            highest_reg         <= '0;
            total_reg           <= '0;
            count_reg           <= '0;
            last_take_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                out_valid_reg <= up_valid;
            end
            if (advance)
            begin
                tracking_before_reg <= up_item.tracking;
                lowest_reg          <= lowest_next;
                highest_reg         <= highest_next;
                total_reg           <= total_next;
                count_reg           <= count_next;
                last_take_reg       <= last_take_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.voltage_mv   <= up_item.voltage_mv;
            out_item_reg.health       <= health;
            out_item_reg.sampled      <= take;
            out_item_reg.min_mv       <= lowest_next;
            out_item_reg.max_mv       <= highest_next;
            out_item_reg.sum_mv       <= total_next;
            out_item_reg.sample_count <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== hdl/bvm_checker.sv =====
// port-level checks of the result channel, bound to the top level
module bvm_checker import bvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      report_valid,
    input  logic      report_ready,
    input  out_item_t report_item
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(report_item))
        else $error("result changed while stalled");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_item.sample_count != '0
        |-> report_item.min_mv <= report_item.max_mv)
        else $error("min above max with samples present");

    a_sampled_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_item.sampled
        |-> report_item.sample_count != '0
            && report_item.min_mv <= report_item.voltage_mv
            && report_item.voltage_mv <= report_item.max_mv
            && report_item.sum_mv >= SUM_W'(report_item.voltage_mv))
        else $error("sampled voltage not reflected in statistics");

    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_item.sample_count == '0
        |-> report_item.min_mv == MV_MAX && report_item.max_mv == '0
            && report_item.sum_mv == '0 && !report_item.sampled)
        else $error("statistics not cleared with zero count");

    a_disconnect: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid
        |-> (report_item.health == HEALTH_DISCONNECTED)
            == (report_item.voltage_mv < MV_DISCONNECT))
        else $error("disconnect grading mismatch");

endmodule

bind battery_voltage_monitor_core bvm_checker u_bvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report.valid),
    .report_ready (report.ready),
    .report_item  (report.item)
);

// ===== tb/battery_voltage_monitor_core_tb.sv =====
// testbench for the battery voltage monitor: directed and random requests checked by a scoreboard
module battery_voltage_monitor_core_tb import bvm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD  = 12.0;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  LONG_HOLD   = 300;
    localparam int  PHASE_ITEMS = 100;

    class bvm_report_board;
        logic [SCALE_W-1:0] mv_scale;
        logic [MV_W-1:0]    critical_mv;
        logic [MV_W-1:0]    warn_mv;
        logic [MV_W-1:0]    full_mv;
        logic [TIME_W-1:0]  interval_us;

        logic               tracking_before;
        logic [MV_W-1:0]    lowest_mv;
        logic [MV_W-1:0]    highest_mv;
        logic [SUM_W-1:0]   total_mv;
        logic [COUNT_W-1:0] taken_count;
        logic [TIME_W-1:0]  last_take_time;

        out_item_t expected_reports[$];
        int        errors;

        function new();
            mv_scale        = MV_SCALE_RESET;
            critical_mv     = CRITICAL_MV_RESET;
            warn_mv         = WARN_MV_RESET;
            full_mv         = FULL_MV_RESET;
            interval_us     = INTERVAL_US_RESET;
            tracking_before = 1'b0;
            errors          = 0;
            clear_stats('0);
        endfunction

        function void clear_stats(logic [TIME_W-1:0] now);
            lowest_mv      = MV_MAX;
            highest_mv     = '0;
            total_mv       = '0;
            taken_count    = '0;
            last_take_time = now;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MV_SCALE:    mv_scale    = val[SCALE_W-1:0];
                REG_CRITICAL_MV: critical_mv = val[MV_W-1:0];
                REG_WARN_MV:     warn_mv     = val[MV_W-1:0];
                REG_FULL_MV:     full_mv     = val[MV_W-1:0];
                REG_INTERVAL_US: interval_us = val[TIME_W-1:0];
                default:         ;
            endcase
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        function void note_request(in_item_t req);
            logic [ADC_SUM_W-1:0] adc_sum;
            logic [PRODUCT_W-1:0] product;
            logic [PRODUCT_W-1:0] scaled;
            logic [MV_W-1:0]      mv;
            logic [MV_W-1:0]      nominal_top;
            logic [TIME_W-1:0]    elapsed;
            logic [SUM_W:0]       wide_total;
            out_item_t            rpt;

            adc_sum = ADC_SUM_W'(req.sample_0) + ADC_SUM_W'(req.sample_1)
                    + ADC_SUM_W'(req.sample_2) + ADC_SUM_W'(req.sample_3);
            product = PRODUCT_W'(adc_sum) * PRODUCT_W'(mv_scale);
            scaled  = product >> FRAC_BITS;
            mv      = (scaled > PRODUCT_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];

            rpt.sampled = 1'b0;
            if (req.tracking && !tracking_before)
            begin
                clear_stats(req.time_us);
            end
            else if (req.tracking)
            begin
                elapsed = req.time_us - last_take_time;
                if (elapsed >= interval_us)
                begin
                    last_take_time = req.time_us;
                    if (mv < lowest_mv)
                        lowest_mv = mv;
                    if (mv > highest_mv)
                        highest_mv = mv;
                    wide_total = {1'b0, total_mv} + (SUM_W+1)'(mv);
                    total_mv   = (wide_total > SUM_LIMIT) ? SUM_LIMIT : wide_total[SUM_W-1:0];
                    if (taken_count != COUNT_LIMIT)
                        taken_count = taken_count + COUNT_W'(1);
                    rpt.sampled = 1'b1;
                end
            end
            tracking_before = req.tracking;

            // checks in fixed order, thresholds need not be ascending
            nominal_top = (full_mv >= MV_FULL_MARGIN) ? full_mv - MV_FULL_MARGIN : '0;
            if (mv < MV_DISCONNECT)
                rpt.health = HEALTH_DISCONNECTED;
            else if (mv < critical_mv)
                rpt.health = HEALTH_CRITICAL;
            else if (mv < warn_mv)
                rpt.health = HEALTH_WARNING;
            else if (mv < nominal_top)
                rpt.health = HEALTH_NOMINAL;
            else
                rpt.health = HEALTH_FULL;

            rpt.voltage_mv   = mv;
            rpt.min_mv       = lowest_mv;
            rpt.max_mv       = highest_mv;
            rpt.sum_mv       = total_mv;
            rpt.sample_count = taken_count;
            expected_reports.push_back(rpt);
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0)
            begin
                $error("report with no request outstanding");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            field_check("voltage_mv", want.voltage_mv, got.voltage_mv);
            field_check("health", want.health, got.health);
            field_check("sampled", want.sampled, got.sampled);
            field_check("min_mv", want.min_mv, got.min_mv);
            field_check("max_mv", want.max_mv, got.max_mv);
            field_check("sum_mv", want.sum_mv, got.sum_mv);
            field_check("sample_count", want.sample_count, got.sample_count);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bvm_in_if  meas_if ();
    bvm_out_if report_if ();

    bvm_report_board sb;

    bit                steady;
    bit                long_hold_req;
    int                hold_left;
    int                cycles;
    logic [TIME_W-1:0] now_us;
    logic              track_on;
    int                level;

    battery_voltage_monitor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas_if),
        .report    (report_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("battery_voltage_monitor_core_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (meas_if.valid && meas_if.ready)
                sb.note_request(meas_if.item);
            if (report_if.valid && report_if.ready)
                sb.check_report(report_if.item);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls plus one long hold when asked
    initial
    begin
        report_if.ready = 1'b0;
        hold_left       = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                report_if.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                report_if.ready <= 1'b0;
            end
            else if (steady)
            begin
                report_if.ready <= 1'b1;
            end
            else
            begin
                hold_left = pick_gap();
                report_if.ready <= (hold_left == 0);
                if (hold_left > 0)
                    hold_left--;
            end
        end
    end

    task automatic send_request(in_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            meas_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        meas_if.valid <= 1'b1;
        meas_if.item  <= req;
        @(posedge clk);
        while (!meas_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        meas_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic program_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [SCALE_W-1:0] scale, logic [MV_W-1:0] crit,
                              logic [MV_W-1:0] warn, logic [MV_W-1:0] full,
                              logic [TIME_W-1:0] interval);
        program_reg(REG_MV_SCALE, CFG_DATA_W'(scale));
        program_reg(REG_CRITICAL_MV, CFG_DATA_W'(crit));
        program_reg(REG_WARN_MV, CFG_DATA_W'(warn));
        program_reg(REG_FULL_MV, CFG_DATA_W'(full));
        program_reg(REG_INTERVAL_US, interval);
    endtask

    function automatic in_item_t flat_request(logic [TIME_W-1:0] t, logic trk,
                                              logic [ADC_BITS-1:0] v);
        in_item_t req;
        req.time_us  = t;
        req.tracking = trk;
        req.sample_0 = v;
        req.sample_1 = v;
        req.sample_2 = v;
        req.sample_3 = v;
        return req;
    endfunction

    function automatic logic [ADC_BITS-1:0] noisy_sample();
        int v;
        if ($urandom_range(0, 9) == 0)
            return ADC_BITS'($urandom());
        v = level + int'($urandom_range(0, 64)) - 32;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return ADC_BITS'(v);
    endfunction

    task automatic random_config();
        logic [SCALE_W-1:0] scale;
        logic [MV_W-1:0]    crit;
        logic [MV_W-1:0]    warn;
        logic [MV_W-1:0]    full;
        logic [TIME_W-1:0]  interval;
        case ($urandom_range(0, 5))
            0:       scale = '0;
            1:       scale = '1;
            2:       scale = SCALE_W'($urandom());
            default: scale = SCALE_W'($urandom_range(20000, 34000));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            crit = MV_W'($urandom());
            warn = MV_W'($urandom());
        end
        else
        begin
            crit = MV_W'($urandom_range(2800, 3600));
            warn = crit + MV_W'($urandom_range(0, 500));
        end
        case ($urandom_range(0, 5))
            0:       full = MV_W'($urandom_range(0, 250));
            1:       full = '1;
            2:       full = MV_W'($urandom());
            default: full = MV_W'($urandom_range(3800, 4400));
        endcase
        case ($urandom_range(0, 7))
            0:       interval = '0;
            1:       interval = '1;
            2:       interval = $urandom();
            default: interval = $urandom_range(0, 3000);
        endcase
        set_config(scale, crit, warn, full, interval);
    endtask

    task automatic run_random_phase(int count);
        longint unsigned cap;
        int              pick;
        in_item_t        req;
        track_on = 1'($urandom_range(0, 1));
        level    = $urandom_range(0, 4095);
        for (int i = 0; i < count; i++)
        begin
            cap = 2 * longint'(sb.interval_us) + 16;
            if (cap > 64'hFFFF_FFFF)
                cap = 64'hFFFF_FFFF;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                now_us = $urandom();
            else if (pick < 15)
                now_us = now_us + sb.interval_us;
            else if (pick < 25)
                now_us = now_us + sb.interval_us - 1;
            else
                now_us = now_us + $urandom_range(0, 32'(cap));
            if ($urandom_range(0, 19) == 0)
                track_on = ~track_on;
            if ($urandom_range(0, 9) == 0)
                level = $urandom_range(0, 4095);
            req.time_us  = now_us;
            req.tracking = track_on;
            req.sample_0 = noisy_sample();
            req.sample_1 = noisy_sample();
            req.sample_2 = noisy_sample();
            req.sample_3 = noisy_sample();
            send_request(req);
        end
        wait_idle();
    endtask

    initial
    begin
        in_item_t req;

        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_MV_SCALE;
        cfg_data       = '0;
        meas_if.valid  = 1'b0;
        meas_if.item   = '0;
        steady         = 1'b0;
        long_hold_req  = 1'b0;
        cycles         = 0;
        now_us         = '0;
        track_on       = 1'b0;
        level          = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes, tracking rise, interval edge, tracking off
        send_request(flat_request(32'd0, 1'b0, 12'd0));
        send_request(flat_request(32'd5, 1'b0, 12'hFFF));
        send_request(flat_request(32'd1000, 1'b1, 12'd2000));
        send_request(flat_request(32'd100999, 1'b1, 12'd2100));
        send_request(flat_request(32'd101000, 1'b1, 12'd2300));
        req = flat_request(32'd201000, 1'b1, 12'hFFF);
        req.sample_1 = '0;
        req.sample_3 = '0;
        send_request(req);
        send_request(flat_request(32'd300000, 1'b0, 12'd2600));
        wait_idle();

        // unity average: voltage equals sample, hits each health boundary
        set_config(SCALE_W'(16384), CRITICAL_MV_RESET, WARN_MV_RESET, FULL_MV_RESET, '0);
        send_request(flat_request(32'd10, 1'b1, 12'd999));
        send_request(flat_request(32'd10, 1'b1, 12'd1000));
        send_request(flat_request(32'd11, 1'b1, 12'd3299));
        send_request(flat_request(32'd12, 1'b1, 12'd3300));
        send_request(flat_request(32'd12, 1'b1, 12'd3499));
        send_request(flat_request(32'd13, 1'b1, 12'd3500));
        send_request(flat_request(32'd14, 1'b1, 12'd3999));
        send_request(flat_request(32'd15, 1'b1, 12'd4000));
        wait_idle();

        // max scale saturation, unordered thresholds, low full, max interval across wrap
        set_config('1, MV_W'(5000), MV_W'(2000), MV_W'(150), '1);
        send_request(flat_request(32'd10, 1'b0, 12'd0));
        send_request(flat_request(32'hFFFF_FFF0, 1'b1, 12'd1));
        send_request(flat_request(32'hFFFF_FFEF, 1'b1, 12'hFFF));
        send_request(flat_request(32'hFFFF_FFEF, 1'b1, 12'd700));
        send_request(flat_request(32'hFFFF_FFF0, 1'b1, 12'd50));
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            steady = (phase == 4);
            if (phase == 0)
                set_config('0, '0, '0, '0, '0);
            else if (phase == 1)
                set_config('1, '1, '1, '1, '1);
            else if (phase == 2)
                set_config(MV_SCALE_RESET, CRITICAL_MV_RESET, WARN_MV_RESET,
                           MV_FULL_MARGIN, 32'd500);
            else
                random_config();
            if (phase == 3)
                long_hold_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("battery_voltage_monitor_core_tb: clean");
        else
            $display("battery_voltage_monitor_core_tb: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/bvm_pkg.sv
hdl/bvm_in_if.sv
hdl/bvm_out_if.sv
hdl/bvm_scale.sv
hdl/bvm_stats.sv
hdl/battery_voltage_monitor_core.sv
hdl/bvm_checker.sv
tb/battery_voltage_monitor_core_tb.sv
